// ===== hw/rtl/rounded_box_hit_test_macros.svh =====
`ifndef ROUNDED_BOX_HIT_TEST_MACROS_SVH
`define ROUNDED_BOX_HIT_TEST_MACROS_SVH

// Check sampled on clk_i that is switched off while reset is asserted.
`define RBHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check sampled on clk_i that also holds while reset is asserted.
`define RBHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/rbht_pkg.sv =====
package rbht_pkg;

  localparam int unsigned COORD_BITS_DEF = 13;

  // Two arcs are evaluated per point: one for the top edge, one for the bottom edge.
  localparam int unsigned ARC_LANES = 2;

  // Sideband carried along the root pipeline: point_y, bottom radius, top radius, flags.
  localparam int unsigned SIDE_W_DEF = 3 * COORD_BITS_DEF + 1;

  // Result payload: inside flag, top edge, bottom edge.
  localparam int unsigned OUT_W_DEF = 2 * COORD_BITS_DEF + 1;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_WIDTH           = 3'd0,
    CFG_BOX_HEIGHT          = 3'd1,
    CFG_RADIUS_TOP_LEFT     = 3'd2,
    CFG_RADIUS_TOP_RIGHT    = 3'd3,
    CFG_RADIUS_BOTTOM_LEFT  = 3'd4,
    CFG_RADIUS_BOTTOM_RIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic col_in;   // point_x lies within 0 .. box_width-1
    logic bot_arc;  // a bottom corner shapes this column
  } rbht_flags_t;

endpackage

// ===== hw/rtl/rbht_prep.sv =====
module rbht_prep #(
  parameter int unsigned COORD_BITS = rbht_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic signed [COORD_BITS:0]    point_x_i,
  input  logic signed [COORD_BITS:0]    point_y_i,
  input  logic [COORD_BITS-1:0]         box_width_i,
  input  logic [COORD_BITS-2:0]         radius_tl_i,
  input  logic [COORD_BITS-2:0]         radius_tr_i,
  input  logic [COORD_BITS-2:0]         radius_bl_i,
  input  logic [COORD_BITS-2:0]         radius_br_i,
  output logic                          vld_o,
  output rbht_pkg::rbht_flags_t         flags_o,
  output logic signed [COORD_BITS:0]    point_y_o,
  output logic [COORD_BITS-2:0]         r_top_o,
  output logic [COORD_BITS-2:0]         r_bot_o,
  output logic [2*COORD_BITS-3:0]       rad_top_o,
  output logic [2*COORD_BITS-3:0]       rad_bot_o
);
  import rbht_pkg::*;

  localparam int unsigned RW = COORD_BITS - 1;
  localparam int unsigned SW = 2 * RW;

  // Stage A: registered input point.
  logic                       vld_a_q;
  logic signed [COORD_BITS:0] x_a_q, y_a_q;

  logic [COORD_BITS-1:0] xu, wx;
  logic                  tl_hit, tr_hit, bl_hit, br_hit;
  logic [RW-1:0]         m_tl, m_tr, m_bl, m_br;
  rbht_flags_t           flags_b_d;
  logic [RW-1:0]         rt_b_d, mt_b_d, rb_b_d, mb_b_d;

  // Stage B: chosen corner radius and distance from the arc center.
  logic                       vld_b_q;
  rbht_flags_t                flags_b_q;
  logic signed [COORD_BITS:0] y_b_q;
  logic [RW-1:0]              rt_b_q, mt_b_q, rb_b_q, mb_b_q;

  // Stage C: squares.
  logic                       vld_c_q;
  rbht_flags_t                flags_c_q;
  logic signed [COORD_BITS:0] y_c_q;
  logic [RW-1:0]              rt_c_q, rb_c_q;
  logic [SW-1:0]              rrt_c_q, mmt_c_q, rrb_c_q, mmb_c_q;

  // Stage D: radicands r*r - dx*dx.
  logic                       vld_d_q;
  rbht_flags_t                flags_d_q;
  logic signed [COORD_BITS:0] y_d_q;
  logic [RW-1:0]              rt_d_q, rb_d_q;
  logic [SW-1:0]              radt_d_q, radb_d_q;

  assign xu = x_a_q[COORD_BITS-1:0];
  assign wx = box_width_i - xu;

  assign tl_hit = (radius_tl_i != '0) && (xu <= {1'b0, radius_tl_i});
  assign bl_hit = (radius_bl_i != '0) && (xu <= {1'b0, radius_bl_i});
  assign tr_hit = (radius_tr_i != '0) && (wx <= {1'b0, radius_tr_i});
  assign br_hit = (radius_br_i != '0) && (wx <= {1'b0, radius_br_i});

  // Left arc: |x - r| = r - x. Right arc: x - (w - r - 1) = r + 1 - (w - x).
  assign m_tl = radius_tl_i - xu[RW-1:0];
  assign m_bl = radius_bl_i - xu[RW-1:0];
  assign m_tr = radius_tr_i - wx[RW-1:0] + RW'(1);
  assign m_br = radius_br_i - wx[RW-1:0] + RW'(1);

  // A column with no corner gets r = 0, which yields a zero root and a zero top edge.
  always_comb begin
    flags_b_d.col_in  = !x_a_q[COORD_BITS] && (xu < box_width_i);
    flags_b_d.bot_arc = bl_hit || br_hit;
    if (tl_hit) begin
      rt_b_d = radius_tl_i;
      mt_b_d = m_tl;
    end else if (tr_hit) begin
      rt_b_d = radius_tr_i;
      mt_b_d = m_tr;
    end else begin
      rt_b_d = '0;
      mt_b_d = '0;
    end
    if (bl_hit) begin
      rb_b_d = radius_bl_i;
      mb_b_d = m_bl;
    end else if (br_hit) begin
      rb_b_d = radius_br_i;
      mb_b_d = m_br;
    end else begin
      rb_b_d = '0;
      mb_b_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_a_q     <= point_x_i;
      y_a_q     <= point_y_i;

      flags_b_q <= flags_b_d;
      y_b_q     <= y_a_q;
      rt_b_q    <= rt_b_d;
      mt_b_q    <= mt_b_d;
      rb_b_q    <= rb_b_d;
      mb_b_q    <= mb_b_d;

      flags_c_q <= flags_b_q;
      y_c_q     <= y_b_q;
      rt_c_q    <= rt_b_q;
      rb_c_q    <= rb_b_q;
      rrt_c_q   <= SW'(rt_b_q) * SW'(rt_b_q);
      mmt_c_q   <= SW'(mt_b_q) * SW'(mt_b_q);
      rrb_c_q   <= SW'(rb_b_q) * SW'(rb_b_q);
      mmb_c_q   <= SW'(mb_b_q) * SW'(mb_b_q);

      flags_d_q <= flags_c_q;
      y_d_q     <= y_c_q;
      rt_d_q    <= rt_c_q;
      rb_d_q    <= rb_c_q;
      radt_d_q  <= rrt_c_q - mmt_c_q;
      radb_d_q  <= rrb_c_q - mmb_c_q;
    end
  end

  assign vld_o     = vld_d_q;
  assign flags_o   = flags_d_q;
  assign point_y_o = y_d_q;
  assign r_top_o   = rt_d_q;
  assign r_bot_o   = rb_d_q;
  assign rad_top_o = radt_d_q;
  assign rad_bot_o = radb_d_q;

endmodule

// ===== hw/rtl/rbht_sqrt.sv =====
module rbht_sqrt #(
  parameter int unsigned RES_W  = rbht_pkg::COORD_BITS_DEF - 1,
  parameter int unsigned SIDE_W = rbht_pkg::SIDE_W_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          vld_i,
  input  logic [rbht_pkg::ARC_LANES-1:0][2*RES_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]                             side_i,
  output logic                                          vld_o,
  output logic [rbht_pkg::ARC_LANES-1:0][RES_W-1:0]     root_o,
  output logic [SIDE_W-1:0]                             side_o
);
  import rbht_pkg::*;

  localparam int unsigned RAD_W = 2 * RES_W;

  // Stage k settles root bit RES_W-1-k; the last stage rounds to nearest.
  logic [RES_W:0]                         vld_q;
  logic [SIDE_W-1:0]                      side_q  [RES_W+1];
  logic [ARC_LANES-1:0][RAD_W-1:0]        rem_q   [RES_W];
  logic [ARC_LANES-1:0][RES_W-1:0]        root_q  [RES_W];
  logic [ARC_LANES-1:0][RES_W-1:0]        rnd_q;

  logic [ARC_LANES-1:0][RAD_W-1:0]        rem_in  [RES_W];
  logic [ARC_LANES-1:0][RAD_W-1:0]        rem_d   [RES_W];
  logic [ARC_LANES-1:0][RAD_W-1:0]        trial   [RES_W];
  logic [ARC_LANES-1:0][RES_W-1:0]        root_in [RES_W];
  logic [ARC_LANES-1:0][RES_W-1:0]        root_d  [RES_W];
  logic [ARC_LANES-1:0][RES_W-1:0]        rnd_d;

  always_comb begin
    rem_in[0]  = rad_i;
    root_in[0] = '0;
    for (int unsigned k = 1; k < RES_W; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
    end
  end

  // The remainder holds n - root^2. Setting bit b adds 2*root*2^b + 4^b to the square.
  always_comb begin
    for (int unsigned k = 0; k < RES_W; k++) begin
      for (int unsigned l = 0; l < ARC_LANES; l++) begin
        trial[k][l] = (RAD_W'(root_in[k][l]) << (RES_W - k)) |
                      (RAD_W'(1) << (2 * (RES_W - 1 - k)));
        if (rem_in[k][l] >= trial[k][l]) begin
          rem_d[k][l]  = rem_in[k][l] - trial[k][l];
          root_d[k][l] = root_in[k][l] | (RES_W'(1) << (RES_W - 1 - k));
        end else begin
          rem_d[k][l]  = rem_in[k][l];
          root_d[k][l] = root_in[k][l];
        end
      end
    end
  end

  // Round up when n - s*s exceeds s; an exact half cannot occur.
  always_comb begin
    for (int unsigned l = 0; l < ARC_LANES; l++) begin
      if (rem_q[RES_W-1][l] > RAD_W'(root_q[RES_W-1][l])) begin
        rnd_d[l] = root_q[RES_W-1][l] + RES_W'(1);
      end else begin
        rnd_d[l] = root_q[RES_W-1][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RES_W-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int unsigned k = 1; k <= RES_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int unsigned k = 0; k < RES_W; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      rnd_q <= rnd_d;
    end
  end

  assign vld_o  = vld_q[RES_W];
  assign root_o = rnd_q;
  assign side_o = side_q[RES_W];

endmodule

// ===== hw/rtl/rbht_skid.sv =====
module rbht_skid #(
  parameter int unsigned DATA_W = rbht_pkg::OUT_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  logic              out_valid_q, skid_valid_q;
  logic [DATA_W-1:0] out_data_q, skid_data_q;
  logic              out_free;

  // The output register drains freely; a second entry catches the transaction
  // that was already on its way when the consumer stalled.
  assign out_free   = out_ready_i || !out_valid_q;
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (!skid_valid_q) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/rounded_box_hit_test.sv =====
// Rounded box hit test. Each transaction on the s_axis side carries one point
// (point_x, point_y) relative to the top-left corner of a box of box_width by
// box_height pixels whose four corners have their own radius; each produces one
// transaction on the m_axis side with the inside flag and the inclusive top and
// exclusive bottom edge of the box in that column (all zero when point_x lies
// outside the columns of the box). A point can be taken on every clock while
// s_axis_tready is high; each point passes through stages that register it,
// select the corner arcs, square and form r*r - dx*dx, then one square-root
// stage per result bit (COORD_BITS-1) plus a rounding stage, then the output
// register. s_axis_tready only drops when the two-entry output buffer is full
// because m_axis_tready was held low. The user must write registers through cfg_we_i,
// cfg_idx_i and cfg_data_i only while no point is in flight; the block does not enforce it.
`include "rounded_box_hit_test_macros.svh"

module rounded_box_hit_test #(
  parameter int unsigned COORD_BITS = rbht_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // s_axis_tdata, lowest bit first: point_x, point_y, zero fill.
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [((2*COORD_BITS+2+7)/8)*8-1:0]         s_axis_tdata,
  // m_axis_tdata, lowest bit first: inside_res, top_edge, bottom_edge, zero fill.
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [((2*COORD_BITS+1+7)/8)*8-1:0]         m_axis_tdata,
  input  logic                                        cfg_we_i,
  input  logic [rbht_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [COORD_BITS-1:0]                       cfg_data_i
);
  import rbht_pkg::*;

  localparam int unsigned RW        = COORD_BITS - 1;
  localparam int unsigned SIDE_W    = 3 * COORD_BITS + 1;
  localparam int unsigned OUT_W     = 2 * COORD_BITS + 1;
  localparam int unsigned M_TDATA_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8;

  logic [COORD_BITS-1:0] box_width_q, box_height_q;
  logic [RW-1:0]         rad_tl_q, rad_tr_q, rad_bl_q, rad_br_q;

  logic en;

  logic                            pre_vld;
  rbht_flags_t                     pre_flags;
  logic signed [COORD_BITS:0]      pre_y;
  logic [RW-1:0]                   pre_rt, pre_rb;
  logic [ARC_LANES-1:0][2*RW-1:0]  pre_rad;

  logic                            sq_vld;
  logic [ARC_LANES-1:0][RW-1:0]    sq_root;
  logic [SIDE_W-1:0]               sq_side;

  rbht_flags_t                     fin_flags;
  logic signed [COORD_BITS:0]      fin_y;
  logic [RW-1:0]                   fin_rt, fin_rb;
  logic signed [COORD_BITS:0]      bot_s;
  logic [COORD_BITS-1:0]           top_edge, bottom_edge;
  logic                            inside_res;
  logic [OUT_W-1:0]                res_data, out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_width_q  <= COORD_BITS'(1);
      box_height_q <= COORD_BITS'(1);
      rad_tl_q     <= '0;
      rad_tr_q     <= '0;
      rad_bl_q     <= '0;
      rad_br_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_BOX_WIDTH:           box_width_q  <= cfg_data_i;
        CFG_BOX_HEIGHT:          box_height_q <= cfg_data_i;
        CFG_RADIUS_TOP_LEFT:     rad_tl_q     <= cfg_data_i[RW-1:0];
        CFG_RADIUS_TOP_RIGHT:    rad_tr_q     <= cfg_data_i[RW-1:0];
        CFG_RADIUS_BOTTOM_LEFT:  rad_bl_q     <= cfg_data_i[RW-1:0];
        CFG_RADIUS_BOTTOM_RIGHT: rad_br_q     <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together whenever the output buffer has room.
  assign s_axis_tready = en;

  rbht_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (s_axis_tvalid),
    .point_x_i   (s_axis_tdata[COORD_BITS:0]),
    .point_y_i   (s_axis_tdata[2*COORD_BITS+1:COORD_BITS+1]),
    .box_width_i (box_width_q),
    .radius_tl_i (rad_tl_q),
    .radius_tr_i (rad_tr_q),
    .radius_bl_i (rad_bl_q),
    .radius_br_i (rad_br_q),
    .vld_o       (pre_vld),
    .flags_o     (pre_flags),
    .point_y_o   (pre_y),
    .r_top_o     (pre_rt),
    .r_bot_o     (pre_rb),
    .rad_top_o   (pre_rad[0]),
    .rad_bot_o   (pre_rad[1])
  );

  rbht_sqrt #(
    .RES_W  (RW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pre_vld),
    .rad_i  (pre_rad),
    .side_i ({pre_y, pre_rb, pre_rt, pre_flags}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign {fin_y, fin_rb, fin_rt, fin_flags} = sq_side;

  // Bottom of a corner column is h - r - 1 + s, clamped at zero.
  assign bot_s = $signed({1'b0, box_height_q}) - $signed({2'b00, fin_rb})
               + $signed({2'b00, sq_root[1]}) - $signed((COORD_BITS + 1)'(1));

  always_comb begin
    if (!fin_flags.col_in) begin
      top_edge    = '0;
      bottom_edge = '0;
    end else begin
      top_edge = COORD_BITS'(fin_rt - sq_root[0]);
      if (!fin_flags.bot_arc) begin
        bottom_edge = box_height_q;
      end else if (bot_s[COORD_BITS]) begin
        bottom_edge = '0;
      end else begin
        bottom_edge = bot_s[COORD_BITS-1:0];
      end
    end
  end

  assign inside_res = fin_flags.col_in
                   && (fin_y >= $signed({1'b0, top_edge}))
                   && (fin_y < $signed({1'b0, bottom_edge}));

  assign res_data = {bottom_edge, top_edge, inside_res};

  rbht_skid #(
    .DATA_W (OUT_W)
  ) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_vld),
    .in_data_i   (res_data),
    .in_ready_o  (en),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = M_TDATA_W'(out_data);

  `RBHT_ASSERT_ALWAYS(a_stall_needs_result, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result pending")
  `RBHT_ASSERT(a_stall_from_output, $rose(!s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready), "input stall without an output stall")
  `RBHT_ASSERT(a_inside_ordered, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[COORD_BITS:1] < m_axis_tdata[2*COORD_BITS:COORD_BITS+1], "inside point with empty column")

endmodule
